@@ src/rsrp_pkg.sv @@
// ----------------------------------------------------------------------------
// rsrp_pkg
// Shared types, codes and decimal helpers for the range scan response parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rsrp_pkg;

  localparam int LINE_BYTES_DEF = 64;

  localparam logic [7:0] ASCII_LF   = 8'h0a;
  localparam logic [3:0] ASCII_DIG_HI = 4'h3;
  localparam logic [6:0] STATUS_GOOD = 7'h30;
  localparam logic [5:0] SEXTET_BIAS = 6'h30;

  // reset values of the configuration registers
  localparam logic [6:0] CMD_RESET     = 7'd71;
  localparam logic [9:0] START_RESET   = 10'd44;
  localparam logic [9:0] END_RESET     = 10'd725;
  localparam logic [6:0] CLUSTER_RESET = 7'd1;

  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_COMMAND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER = 2'd3;

  localparam logic [1:0] KIND_RANGE    = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_FAULT    = 2'd2;

  localparam logic [1:0] CAUSE_COMMAND = 2'd0;
  localparam logic [1:0] CAUSE_ECHO    = 2'd1;
  localparam logic [1:0] CAUSE_LF      = 2'd2;
  localparam logic [1:0] CAUSE_BIT7    = 2'd3;

  localparam logic [2:0] ECHO_START_HUND = 3'd0;
  localparam logic [2:0] ECHO_START_TENS = 3'd1;
  localparam logic [2:0] ECHO_START_UNIT = 3'd2;
  localparam logic [2:0] ECHO_END_HUND   = 3'd3;
  localparam logic [2:0] ECHO_END_TENS   = 3'd4;
  localparam logic [2:0] ECHO_END_UNIT   = 3'd5;
  localparam logic [2:0] ECHO_CLU_TENS   = 3'd6;
  localparam logic [2:0] ECHO_CLU_UNIT   = 3'd7;

  typedef enum logic [8:0] {
    PH_IDLE    = 9'b000000001,
    PH_ECHO    = 9'b000000010,
    PH_LF_A    = 9'b000000100,
    PH_STATUS  = 9'b000001000,
    PH_LF_B    = 9'b000010000,
    PH_DATA_HI = 9'b000100000,
    PH_DATA_LO = 9'b001000000,
    PH_DATA_LF = 9'b010000000,
    PH_END_LF  = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] unit;
  } dec3_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] range_value;
    logic [6:0]  status_code;
    logic        status_bad;
    logic [1:0]  fault_cause;
  } result_t;

  // decimal digits of a 10-bit value, hundreds taken modulo 10
  function automatic dec3_t dec3(input logic [9:0] v);
    dec3_t      d;
    logic [9:0] r;
    logic [6:0] r7;
    logic [6:0] u;
    d = '0;
    r = v;
    for (int k = 1; k <= 10; k++) begin
      if (v >= 10'(k * 100)) begin
        d.hund = 4'(k);
        r      = v - 10'(k * 100);
      end
    end
    if (d.hund == 4'd10) begin
      d.hund = 4'd0;
    end
    r7 = r[6:0];
    u  = r7;
    for (int k = 1; k <= 9; k++) begin
      if (r7 >= 7'(k * 10)) begin
        d.tens = 4'(k);
        u      = r7 - 7'(k * 10);
      end
    end
    d.unit = u[3:0];
    return d;
  endfunction

endpackage

`default_nettype wire

@@ src/range_scan_response_parser.sv @@
// ----------------------------------------------------------------------------
// range_scan_response_parser
// Byte-wise decoder for a distance-scan reply of a laser range finder.
//
// Input stream s_axis carries one received byte per request. Output stream
// m_axis carries at most one result per byte: tuser gives the kind (range
// sample, reply complete, protocol fault), tdata the range, latched status,
// status flag and fault cause. The cfg port writes the expected command byte,
// start step, end step and cluster count; echo digits are split into decimal
// form when a register is written.
// Each byte is decoded combinationally by the phase logic; on the accepting
// edge its result is registered in the output register, or in the skid
// buffer while the output register holds a waiting result. A byte can be
// taken every cycle while the skid buffer is empty, since tready drops only
// when both the output register and the one-entry skid buffer hold a result.
// Reset (synchronous) returns the parser to idle awaiting a command byte,
// empties both result stages and restores the configuration reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module range_scan_response_parser #(
  parameter int LINE_BYTES = rsrp_pkg::LINE_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [7:0]                     s_axis_tdata,  // [7:0] rx_byte
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [11:0] range_value, [18:12] status_code, [19] status_bad,
  // [21:20] fault_cause, [23:22] zero
  output logic [23:0]                         m_axis_tdata,
  output logic [1:0]                          m_axis_tuser,  // [1:0] kind
  input  wire logic                           cfg_we,
  input  wire logic [rsrp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rsrp_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(LINE_BYTES + 2);
  localparam logic [CNT_W-1:0] LINE_END = CNT_W'(LINE_BYTES);

  // configuration
  logic [6:0]      command_code;
  rsrp_pkg::dec3_t start_dig;
  rsrp_pkg::dec3_t end_dig;
  rsrp_pkg::dec3_t clu_dig;

  // parser state
  rsrp_pkg::phase_t phase, phase_next;
  logic [2:0]       echo_position, echo_position_next;
  logic [CNT_W-1:0] line_byte_count, line_byte_count_next;
  logic [5:0]       high_sextet, high_sextet_next;
  logic [6:0]       latched_status, latched_status_next;
  logic             echo_miss, echo_miss_next;

  // result stages
  logic             out_valid;
  rsrp_pkg::result_t out_res;
  logic             skid_valid;
  rsrp_pkg::result_t skid_res;

  logic              accept;
  logic              take;
  logic              produce;
  rsrp_pkg::result_t res;

  logic [7:0]       b;
  logic [3:0]       want_digit;
  logic             echo_bad;
  logic             group_end;
  logic [CNT_W-1:0] cnt_inc;
  logic [5:0]       sextet;

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign take          = out_valid && m_axis_tready;
  assign b             = s_axis_tdata;
  assign cnt_inc       = line_byte_count + CNT_W'(1);
  assign sextet        = b[5:0] - rsrp_pkg::SEXTET_BIAS;

  always_comb begin
    case (echo_position)
      rsrp_pkg::ECHO_START_HUND: want_digit = start_dig.hund;
      rsrp_pkg::ECHO_START_TENS: want_digit = start_dig.tens;
      rsrp_pkg::ECHO_START_UNIT: want_digit = start_dig.unit;
      rsrp_pkg::ECHO_END_HUND:   want_digit = end_dig.hund;
      rsrp_pkg::ECHO_END_TENS:   want_digit = end_dig.tens;
      rsrp_pkg::ECHO_END_UNIT:   want_digit = end_dig.unit;
      rsrp_pkg::ECHO_CLU_TENS:   want_digit = clu_dig.tens;
      default:                   want_digit = clu_dig.unit;
    endcase
  end

  assign echo_bad  = b != {rsrp_pkg::ASCII_DIG_HI, want_digit};
  assign group_end = echo_position inside {rsrp_pkg::ECHO_START_UNIT,
                                           rsrp_pkg::ECHO_END_UNIT,
                                           rsrp_pkg::ECHO_CLU_UNIT};

  always_comb begin
    phase_next           = phase;
    echo_position_next   = echo_position;
    line_byte_count_next = line_byte_count;
    high_sextet_next     = high_sextet;
    latched_status_next  = latched_status;
    echo_miss_next       = echo_miss;
    produce              = 1'b0;
    res                  = '0;

    if (b[7]) begin
      produce         = 1'b1;
      res.kind        = rsrp_pkg::KIND_FAULT;
      res.fault_cause = rsrp_pkg::CAUSE_BIT7;
      phase_next      = rsrp_pkg::PH_IDLE;
    end else begin
      case (phase)
        rsrp_pkg::PH_IDLE: begin
          if (b[6:0] != command_code) begin
            produce         = 1'b1;
            res.kind        = rsrp_pkg::KIND_FAULT;
            res.fault_cause = rsrp_pkg::CAUSE_COMMAND;
          end else begin
            phase_next         = rsrp_pkg::PH_ECHO;
            echo_position_next = '0;
            echo_miss_next     = 1'b0;
          end
        end
        rsrp_pkg::PH_ECHO: begin
          echo_miss_next     = echo_miss || echo_bad;
          echo_position_next = echo_position + 3'd1;
          if (group_end && echo_miss_next) begin
            produce         = 1'b1;
            res.kind        = rsrp_pkg::KIND_FAULT;
            res.fault_cause = rsrp_pkg::CAUSE_ECHO;
            phase_next      = rsrp_pkg::PH_IDLE;
          end else if (echo_position == rsrp_pkg::ECHO_CLU_UNIT) begin
            phase_next = rsrp_pkg::PH_LF_A;
          end
        end
        rsrp_pkg::PH_LF_A: begin
          if (b != rsrp_pkg::ASCII_LF) begin
            produce         = 1'b1;
            res.kind        = rsrp_pkg::KIND_FAULT;
            res.fault_cause = rsrp_pkg::CAUSE_LF;
            phase_next      = rsrp_pkg::PH_IDLE;
          end else begin
            phase_next = rsrp_pkg::PH_STATUS;
          end
        end
        rsrp_pkg::PH_STATUS: begin
          latched_status_next = b[6:0];
          phase_next          = rsrp_pkg::PH_LF_B;
        end
        rsrp_pkg::PH_LF_B: begin
          if (b != rsrp_pkg::ASCII_LF) begin
            produce         = 1'b1;
            res.kind        = rsrp_pkg::KIND_FAULT;
            res.fault_cause = rsrp_pkg::CAUSE_LF;
            phase_next      = rsrp_pkg::PH_IDLE;
          end else begin
            line_byte_count_next = '0;
            phase_next           = rsrp_pkg::PH_DATA_HI;
          end
        end
        rsrp_pkg::PH_DATA_HI: begin
          line_byte_count_next = cnt_inc;
          if (b == rsrp_pkg::ASCII_LF) begin
            if (cnt_inc < LINE_END) begin
              phase_next = rsrp_pkg::PH_END_LF;
            end else begin
              // ending LF landed on the line boundary: reply is done
              produce         = 1'b1;
              res.kind        = rsrp_pkg::KIND_COMPLETE;
              res.status_code = latched_status;
              res.status_bad  = latched_status != rsrp_pkg::STATUS_GOOD;
              phase_next      = rsrp_pkg::PH_IDLE;
            end
          end else begin
            high_sextet_next = sextet;
            phase_next       = rsrp_pkg::PH_DATA_LO;
          end
        end
        rsrp_pkg::PH_DATA_LO: begin
          produce         = 1'b1;
          res.kind        = rsrp_pkg::KIND_RANGE;
          res.range_value = {high_sextet, sextet};
          if (cnt_inc >= LINE_END) begin
            line_byte_count_next = '0;
            phase_next           = rsrp_pkg::PH_DATA_LF;
          end else begin
            line_byte_count_next = cnt_inc;
            phase_next           = rsrp_pkg::PH_DATA_HI;
          end
        end
        rsrp_pkg::PH_DATA_LF: begin
          if (b != rsrp_pkg::ASCII_LF) begin
            produce         = 1'b1;
            res.kind        = rsrp_pkg::KIND_FAULT;
            res.fault_cause = rsrp_pkg::CAUSE_LF;
            phase_next      = rsrp_pkg::PH_IDLE;
          end else begin
            phase_next = rsrp_pkg::PH_DATA_HI;
          end
        end
        rsrp_pkg::PH_END_LF: begin
          produce    = 1'b1;
          phase_next = rsrp_pkg::PH_IDLE;
          if (b != rsrp_pkg::ASCII_LF) begin
            res.kind        = rsrp_pkg::KIND_FAULT;
            res.fault_cause = rsrp_pkg::CAUSE_LF;
          end else begin
            res.kind        = rsrp_pkg::KIND_COMPLETE;
            res.status_code = latched_status;
            res.status_bad  = latched_status != rsrp_pkg::STATUS_GOOD;
          end
        end
        default: begin
          phase_next = rsrp_pkg::PH_IDLE;
        end
      endcase
    end

    // leaving for idle drops the per-reply context
    if (phase_next == rsrp_pkg::PH_IDLE) begin
      echo_position_next   = '0;
      line_byte_count_next = '0;
      high_sextet_next     = '0;
      echo_miss_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_code <= rsrp_pkg::CMD_RESET;
      start_dig    <= rsrp_pkg::dec3(rsrp_pkg::START_RESET);
      end_dig      <= rsrp_pkg::dec3(rsrp_pkg::END_RESET);
      clu_dig      <= rsrp_pkg::dec3({3'b000, rsrp_pkg::CLUSTER_RESET});
    end else if (cfg_we) begin
      case (cfg_index)
        rsrp_pkg::REG_COMMAND: command_code <= cfg_data[6:0];
        rsrp_pkg::REG_START:   start_dig    <= rsrp_pkg::dec3(cfg_data);
        rsrp_pkg::REG_END:     end_dig      <= rsrp_pkg::dec3(cfg_data);
        rsrp_pkg::REG_CLUSTER: clu_dig      <= rsrp_pkg::dec3({3'b000, cfg_data[6:0]});
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= rsrp_pkg::PH_IDLE;
      echo_position   <= '0;
      line_byte_count <= '0;
      high_sextet     <= '0;
      latched_status  <= '0;
      echo_miss       <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      echo_position   <= echo_position_next;
      line_byte_count <= line_byte_count_next;
      high_sextet     <= high_sextet_next;
      latched_status  <= latched_status_next;
      echo_miss       <= echo_miss_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept && produce;
        out_res   <= res;
      end
    end else if (accept && produce) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
        out_res   <= res;
      end else begin
        skid_valid <= 1'b1;
        skid_res   <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tdata  = {2'b00, out_res.fault_cause, out_res.status_bad,
                          out_res.status_code, out_res.range_value};

endmodule

`default_nettype wire
